[hdl/bmhq_pkg.sv]
// Shared types and constants for the binary min-heap priority queue.
// Used by bmhq_ctrl, bmhq_dpath and binary_min_heap_queue; no dependencies.
package bmhq_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int AW = $clog2(HEAP_DEPTH);       // slot address width
  localparam int CW = $clog2(HEAP_DEPTH + 1);   // entry count width
  localparam int LW = AW + 1;                   // child index width

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] prio;
    logic        [31:0] payload;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_REJECT,
    CMD_UP_INIT,
    CMD_UP_READ,
    CMD_UP_MOVE,
    CMD_UP_PLACE,
    CMD_DN_INIT,
    CMD_DN_LOAD,
    CMD_DN_READ,
    CMD_DN_MOVE,
    CMD_DN_PLACE
  } cmd_e;

  typedef struct packed {
    logic is_deq;
    logic full;
    logic empty;
    logic at_root;
    logic up_less;
    logic dn_leaf;
    logic dn_less;
  } stat_t;

endpackage

[hdl/bmhq_ctrl.sv]
// Sequencer for the min-heap queue: walks the sift-up and sift-down loops.
// Depends on bmhq_pkg; drives commands into bmhq_dpath and reads its status.
module bmhq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bmhq_pkg::stat_t stat_i,
  output bmhq_pkg::cmd_e  cmd_o,
  output logic            busy_o
);

  bmhq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (start_i) state_d = bmhq_pkg::S_DECIDE;
      end
      bmhq_pkg::S_DECIDE: begin
        if (stat_i.is_deq) begin
          state_d = stat_i.empty ? bmhq_pkg::S_IDLE : bmhq_pkg::S_DN_LOAD;
        end else begin
          state_d = stat_i.full ? bmhq_pkg::S_IDLE : bmhq_pkg::S_UP_RD;
        end
      end
      bmhq_pkg::S_UP_RD: begin
        state_d = stat_i.at_root ? bmhq_pkg::S_IDLE : bmhq_pkg::S_UP_CMP;
      end
      bmhq_pkg::S_UP_CMP: begin
        state_d = stat_i.up_less ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_IDLE;
      end
      bmhq_pkg::S_DN_LOAD: begin
        state_d = bmhq_pkg::S_DN_RD;
      end
      bmhq_pkg::S_DN_RD: begin
        state_d = stat_i.dn_leaf ? bmhq_pkg::S_IDLE : bmhq_pkg::S_DN_CMP;
      end
      bmhq_pkg::S_DN_CMP: begin
        state_d = stat_i.dn_less ? bmhq_pkg::S_DN_RD : bmhq_pkg::S_IDLE;
      end
      default: state_d = bmhq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = bmhq_pkg::CMD_NONE;
    busy_o = (state_q != bmhq_pkg::S_IDLE);
    case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (start_i) cmd_o = bmhq_pkg::CMD_ACCEPT;
      end
      bmhq_pkg::S_DECIDE: begin
        if (stat_i.is_deq) begin
          cmd_o = stat_i.empty ? bmhq_pkg::CMD_REJECT : bmhq_pkg::CMD_DN_INIT;
        end else begin
          cmd_o = stat_i.full ? bmhq_pkg::CMD_REJECT : bmhq_pkg::CMD_UP_INIT;
        end
      end
      bmhq_pkg::S_UP_RD: begin
        cmd_o = stat_i.at_root ? bmhq_pkg::CMD_UP_PLACE : bmhq_pkg::CMD_UP_READ;
      end
      bmhq_pkg::S_UP_CMP: begin
        cmd_o = stat_i.up_less ? bmhq_pkg::CMD_UP_MOVE : bmhq_pkg::CMD_UP_PLACE;
      end
      bmhq_pkg::S_DN_LOAD: begin
        cmd_o = bmhq_pkg::CMD_DN_LOAD;
      end
      bmhq_pkg::S_DN_RD: begin
        cmd_o = stat_i.dn_leaf ? bmhq_pkg::CMD_DN_PLACE : bmhq_pkg::CMD_DN_READ;
      end
      bmhq_pkg::S_DN_CMP: begin
        cmd_o = stat_i.dn_less ? bmhq_pkg::CMD_DN_MOVE : bmhq_pkg::CMD_DN_PLACE;
      end
      default: cmd_o = bmhq_pkg::CMD_NONE;
    endcase
  end

endmodule

[hdl/bmhq_dpath.sv]
// Datapath of the min-heap queue: heap memory, hole pointer, entry count,
// key compares and result registers. Depends on bmhq_pkg; driven by bmhq_ctrl.
module bmhq_dpath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    action_i,
  input  logic signed [31:0]      in_priority_i,
  input  logic        [31:0]      in_payload_i,
  input  bmhq_pkg::cmd_e          cmd_i,
  output bmhq_pkg::stat_t         stat_o,
  output logic                    done_o,
  output logic signed [31:0]      out_priority_o,
  output logic        [31:0]      out_payload_o,
  output logic        [1:0]       status_o,
  output logic [bmhq_pkg::CW-1:0] occupancy_o
);

  bmhq_pkg::entry_t  mem_q [bmhq_pkg::HEAP_DEPTH];
  bmhq_pkg::entry_t  rd_a_q, rd_b_q;
  bmhq_pkg::entry_t  entry_q, res_q;
  bmhq_pkg::status_e status_q;
  logic                    act_q;
  logic                    done_q;
  logic [bmhq_pkg::AW-1:0] hole_q;
  logic [bmhq_pkg::CW-1:0] count_q;

  logic [bmhq_pkg::LW-1:0] left, right, count_ext;
  logic [bmhq_pkg::AW-1:0] parent, pick_idx;
  logic                    pick_right;
  bmhq_pkg::entry_t        pick;

  logic                    wr_en, rd_en;
  logic [bmhq_pkg::AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  bmhq_pkg::entry_t        wr_data;
  logic                    finish;

  assign left       = {hole_q, 1'b1};
  assign right      = left + bmhq_pkg::LW'(1);
  assign count_ext  = bmhq_pkg::LW'(count_q);
  assign parent     = (hole_q - bmhq_pkg::AW'(1)) >> 1;
  // take the right child only when it exists and is strictly smaller
  assign pick_right = (right < count_ext) && ($signed(rd_b_q.prio) < $signed(rd_a_q.prio));
  assign pick       = pick_right ? rd_b_q : rd_a_q;
  assign pick_idx   = pick_right ? right[bmhq_pkg::AW-1:0] : left[bmhq_pkg::AW-1:0];

  assign stat_o.is_deq  = act_q;
  assign stat_o.full    = (count_q == bmhq_pkg::CW'(bmhq_pkg::HEAP_DEPTH));
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.at_root = (hole_q == '0);
  assign stat_o.up_less = ($signed(entry_q.prio) < $signed(rd_a_q.prio));
  assign stat_o.dn_leaf = (left >= count_ext);
  assign stat_o.dn_less = ($signed(pick.prio) < $signed(entry_q.prio));

  assign finish = (cmd_i == bmhq_pkg::CMD_REJECT) || (cmd_i == bmhq_pkg::CMD_UP_PLACE) ||
                  (cmd_i == bmhq_pkg::CMD_DN_PLACE);

  // Memory port control: the sifted entry rides in entry_q, only the hole moves.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = hole_q;
    wr_data   = entry_q;
    rd_en     = 1'b0;
    rd_addr_a = '0;
    rd_addr_b = '0;
    case (cmd_i)
      bmhq_pkg::CMD_UP_READ: begin
        rd_en     = 1'b1;
        rd_addr_a = parent;
      end
      bmhq_pkg::CMD_UP_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_a_q;
      end
      bmhq_pkg::CMD_UP_PLACE, bmhq_pkg::CMD_DN_PLACE: begin
        wr_en = 1'b1;
      end
      bmhq_pkg::CMD_DN_INIT: begin
        rd_en     = 1'b1;
        rd_addr_a = '0;
        rd_addr_b = bmhq_pkg::AW'(count_q - bmhq_pkg::CW'(1));
      end
      bmhq_pkg::CMD_DN_READ: begin
        rd_en     = 1'b1;
        rd_addr_a = left[bmhq_pkg::AW-1:0];
        rd_addr_b = right[bmhq_pkg::AW-1:0];
      end
      bmhq_pkg::CMD_DN_MOVE: begin
        wr_en   = 1'b1;
        wr_data = pick;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_a_q <= mem_q[rd_addr_a];
      rd_b_q <= mem_q[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= finish;
      case (cmd_i)
        bmhq_pkg::CMD_UP_INIT: count_q <= count_q + bmhq_pkg::CW'(1);
        bmhq_pkg::CMD_DN_INIT: count_q <= count_q - bmhq_pkg::CW'(1);
        default:               count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      bmhq_pkg::CMD_ACCEPT: begin
        act_q   <= action_i;
        entry_q <= {in_priority_i, in_payload_i};
      end
      bmhq_pkg::CMD_REJECT: begin
        res_q    <= '0;
        status_q <= act_q ? bmhq_pkg::STAT_EMPTY : bmhq_pkg::STAT_FULL;
      end
      bmhq_pkg::CMD_UP_INIT: begin
        res_q    <= '0;
        status_q <= bmhq_pkg::STAT_OK;
        hole_q   <= count_q[bmhq_pkg::AW-1:0];
      end
      bmhq_pkg::CMD_UP_MOVE: begin
        hole_q <= parent;
      end
      bmhq_pkg::CMD_DN_INIT: begin
        status_q <= bmhq_pkg::STAT_OK;
        hole_q   <= '0;
      end
      bmhq_pkg::CMD_DN_LOAD: begin
        // root goes out, last entry starts its walk down from the root
        res_q   <= rd_a_q;
        entry_q <= rd_b_q;
      end
      bmhq_pkg::CMD_DN_MOVE: begin
        hole_q <= pick_idx;
      end
      default: hole_q <= hole_q;
    endcase
  end

  assign done_o         = done_q;
  assign out_priority_o = res_q.prio;
  assign out_payload_o  = res_q.payload;
  assign status_o       = status_q;
  assign occupancy_o    = count_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bmhq_pkg::CW'(bmhq_pkg::HEAP_DEPTH))
    else $error("entry count above heap depth");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == bmhq_pkg::STAT_FULL) |->
      (count_q == bmhq_pkg::CW'(bmhq_pkg::HEAP_DEPTH) && res_q == '0))
    else $error("dropped enqueue reported with wrong count or data");

  a_empty_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == bmhq_pkg::STAT_EMPTY) |-> (count_q == '0 && res_q == '0))
    else $error("empty dequeue reported with wrong count or data");

  a_up_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == bmhq_pkg::CMD_UP_MOVE) |-> (hole_q != '0))
    else $error("sift-up moved past the root");

endmodule

[hdl/binary_min_heap_queue.sv]
// Binary min-heap priority queue of (priority, payload) entries, top level.
// Depends on bmhq_pkg, bmhq_ctrl and bmhq_dpath.
//
// Pulse start_i with action_i, in_priority_i and in_payload_i while busy_o is
// low; the transaction is taken at that clock edge. Exactly one result follows,
// marked by done_o for one cycle, which the receiver must take at once. With
// 64 entries an enqueue climbs at most six levels, up to the root. Every level
// of a sift costs one registered read of the heap RAM and a key compare with a
// write back; on the way down the read fetches both children and a further
// compare picks the smaller of them. busy_o is low again in the cycle that
// done_o is high, so the next transaction may be started then. Dequeue returns
// the entry of smallest signed priority; ties come out in no guaranteed order.
// An enqueue on a full heap is dropped with status 2, a dequeue on an empty
// heap gives status 1; out_priority_o and out_payload_o are zero except for a
// successful dequeue.
module binary_min_heap_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    action_i,
  input  logic signed [31:0]      in_priority_i,
  input  logic        [31:0]      in_payload_i,
  output logic                    done_o,
  output logic signed [31:0]      out_priority_o,
  output logic        [31:0]      out_payload_o,
  output logic        [1:0]       status_o,
  output logic [bmhq_pkg::CW-1:0] occupancy_o
);

  bmhq_pkg::cmd_e  cmd;
  bmhq_pkg::stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  bmhq_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (action_i),
    .in_priority_i  (in_priority_i),
    .in_payload_i   (in_payload_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .done_o         (done_o),
    .out_priority_o (out_priority_o),
    .out_payload_o  (out_payload_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

[verif/tb_binary_min_heap_queue.sv]
`timescale 1ns / 1ps
// Self-checking testbench for binary_min_heap_queue: directed and random
// enqueue/dequeue traffic checked against a behavioral heap. Needs bmhq_pkg.
module tb_binary_min_heap_queue;

  localparam int CLK_PERIOD  = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [31:0]      res_prio;
    logic        [31:0]      res_data;
    bmhq_pkg::status_e       res_status;
    logic [bmhq_pkg::CW-1:0] res_occ;
  } heap_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic                    action_i;
  logic signed [31:0]      in_priority_i;
  logic        [31:0]      in_payload_i;
  logic                    done_o;
  logic signed [31:0]      out_priority_o;
  logic        [31:0]      out_payload_o;
  logic        [1:0]       status_o;
  logic [bmhq_pkg::CW-1:0] occupancy_o;

  // behavioral heap state
  logic signed [31:0] heap_key [bmhq_pkg::HEAP_DEPTH];
  logic        [31:0] heap_data [bmhq_pkg::HEAP_DEPTH];
  int                 heap_count;
  heap_result_t       pending_results[$];

  int  error_count;
  int  op_count;
  int  n_served;
  int  n_empty;
  int  n_dropped;
  int  peak_occ;
  int  cycle_count;
  bit  gaps_on;

  binary_min_heap_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .in_priority_i  (in_priority_i),
    .in_payload_i   (in_payload_i),
    .done_o         (done_o),
    .out_priority_o (out_priority_o),
    .out_payload_o  (out_payload_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void swap_slots(int i, int j);
    logic signed [31:0] tk;
    logic        [31:0] td;
    tk = heap_key[i];
    td = heap_data[i];
    heap_key[i] = heap_key[j];
    heap_data[i] = heap_data[j];
    heap_key[j] = tk;
    heap_data[j] = td;
  endfunction

  // Apply one transaction to the behavioral heap and queue its result.
  function automatic void predict_heap_op(logic act, logic signed [31:0] prio,
                                          logic [31:0] data);
    heap_result_t r;
    int pos;
    int parent;
    int left;
    int right;
    int pick;
    r.res_prio   = '0;
    r.res_data   = '0;
    r.res_status = bmhq_pkg::STAT_OK;
    if (!act) begin
      if (heap_count >= bmhq_pkg::HEAP_DEPTH) begin
        r.res_status = bmhq_pkg::STAT_FULL;
        n_dropped++;
      end else begin
        heap_key[heap_count] = prio;
        heap_data[heap_count] = data;
        pos = heap_count;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!(heap_key[pos] < heap_key[parent])) break;
          swap_slots(pos, parent);
          pos = parent;
        end
        heap_count++;
        if (heap_count > peak_occ) peak_occ = heap_count;
      end
    end else begin
      if (heap_count == 0) begin
        r.res_status = bmhq_pkg::STAT_EMPTY;
        n_empty++;
      end else begin
        r.res_prio = heap_key[0];
        r.res_data = heap_data[0];
        heap_count--;
        heap_key[0] = heap_key[heap_count];
        heap_data[0] = heap_data[heap_count];
        pos = 0;
        forever begin
          left = 2 * pos + 1;
          right = left + 1;
          if (left >= heap_count) break;
          pick = left;
          // ties between children go left
          if (right < heap_count && heap_key[right] < heap_key[left]) pick = right;
          if (!(heap_key[pick] < heap_key[pos])) break;
          swap_slots(pos, pick);
          pos = pick;
        end
        n_served++;
      end
    end
    r.res_occ = heap_count[bmhq_pkg::CW-1:0];
    pending_results.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v,
                                      logic [31:0] act_v);
    if (act_v !== exp_v) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    heap_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual prio %0h payload %0h",
                 $time, out_priority_o, out_payload_o);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("out_priority", exp_r.res_prio, out_priority_o);
        check_field("out_payload", exp_r.res_data, out_payload_o);
        check_field("status", 32'(exp_r.res_status), 32'(status_o));
        check_field("occupancy", 32'(exp_r.res_occ), 32'(occupancy_o));
      end
    end
  end

  // Hold start high until the transaction is taken; randomize idle fields.
  task automatic send_op(input logic act, input logic signed [31:0] prio,
                         input logic [31:0] data);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start_i       <= 1'b0;
      action_i      <= 1'($urandom);
      in_priority_i <= $urandom;
      in_payload_i  <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
    start_i       <= 1'b1;
    action_i      <= act;
    in_priority_i <= prio;
    in_payload_i  <= data;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_heap_op(act, prio, data);
    op_count++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_key(bit narrow);
    int sel;
    sel = $urandom_range(0, 9);
    if (narrow || sel < 4) return 32'($signed($urandom_range(0, 8)) - 4);
    if (sel == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic test_empty_dequeue();
    send_op(1'b1, 32'sd0, 32'd0);
    send_op(1'b1, -32'sd1, 32'hffff_ffff);
    drain_results();
  endtask

  task automatic test_key_extremes();
    send_op(1'b0, 32'sh7fff_ffff, 32'h0000_0000);
    send_op(1'b0, 32'sh8000_0000, 32'hffff_ffff);
    send_op(1'b0, 32'sh0, 32'ha5a5_a5a5);
    send_op(1'b0, -32'sd1, 32'h5a5a_5a5a);
    repeat (5) send_op(1'b1, 32'sd0, 32'd0);
    drain_results();
  endtask

  // Equal children after a dequeue: the left one must win.
  task automatic test_equal_keys();
    send_op(1'b0, 32'sd1, 32'd11);
    send_op(1'b0, 32'sd7, 32'd22);
    send_op(1'b0, 32'sd7, 32'd33);
    send_op(1'b0, 32'sd9, 32'd44);
    repeat (4) send_op(1'b1, 32'sd0, 32'd0);
    drain_results();
  endtask

  task automatic test_fill_and_drain(input bit narrow);
    while (heap_count < bmhq_pkg::HEAP_DEPTH) send_op(1'b0, rand_key(narrow), $urandom);
    repeat (2) send_op(1'b0, rand_key(narrow), $urandom);
    while (heap_count > 0) send_op(1'b1, $urandom, $urandom);
    repeat (2) send_op(1'b1, $urandom, $urandom);
    drain_results();
  endtask

  // Vary the enqueue share per chunk so occupancy wanders across the range.
  task automatic test_random_mix(input int n_items);
    int enq_pct;
    logic act;
    enq_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 25;
          1: enq_pct = 50;
          default: enq_pct = 80;
        endcase
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      act = ($urandom_range(0, 99) >= enq_pct);
      send_op(act, rand_key(1'b0), $urandom);
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    action_i      = 1'b0;
    in_priority_i = '0;
    in_payload_i  = '0;
    heap_count    = 0;
    error_count   = 0;
    op_count      = 0;
    n_served      = 0;
    n_empty       = 0;
    n_dropped     = 0;
    peak_occ      = 0;
    gaps_on       = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_dequeue();
    test_key_extremes();
    test_equal_keys();
    test_fill_and_drain(1'b1);
    test_random_mix(1000);
    test_fill_and_drain(1'b0);

    $display("Ran %0d transactions: %0d entries served, %0d empty dequeues,",
             op_count, n_served, n_empty);
    $display("%0d enqueues dropped on a full heap, peak occupancy %0d.",
             n_dropped, peak_occ);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[binary_min_heap_queue.f]
hdl/bmhq_pkg.sv
hdl/bmhq_ctrl.sv
hdl/bmhq_dpath.sv
hdl/binary_min_heap_queue.sv
verif/tb_binary_min_heap_queue.sv
